>>> rtl/lr_pkg.sv
// Shared constants and types for the line rasterizer.
`default_nettype none

package lr_pkg;

  // Coordinate and payload widths
  localparam int X_W     = 9;
  localparam int Y_W     = 8;
  localparam int POS_W   = 9;
  localparam int ERR_W   = 10;
  localparam int COLOR_W = 16;
  localparam int ADDR_W  = 32;

  // Parameter defaults
  localparam int X_LIMIT_DEF = 319;
  localparam int Y_LIMIT_DEF = 239;

  // Frame base after reset
  localparam logic [ADDR_W-1:0] FRAME_BASE_RST = 32'hC800_0000;

  // Action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  // One input word
  typedef struct packed {
    logic               action;
    logic [X_W-1:0]     start_x;
    logic [Y_W-1:0]     start_y;
    logic [X_W-1:0]     end_x;
    logic [Y_W-1:0]     end_y;
    logic [COLOR_W-1:0] color;
  } lr_item_t;

  // One output word
  typedef struct packed {
    logic [X_W-1:0]     pixel_x;
    logic [Y_W-1:0]     pixel_y;
    logic [ADDR_W-1:0]  address;
    logic [COLOR_W-1:0] pixel_color;
    logic               last;
  } lr_pixel_t;

  // Engine result towards the output register
  typedef struct packed {
    logic      valid;
    lr_pixel_t pixel;
  } lr_result_t;

endpackage

`default_nettype wire

>>> rtl/lr_if.sv
// Valid/ready channel interfaces for line commands and pixel writes.
`default_nettype none

interface lr_in_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [lr_pkg::X_W-1:0]     start_x;
  logic [lr_pkg::Y_W-1:0]     start_y;
  logic [lr_pkg::X_W-1:0]     end_x;
  logic [lr_pkg::Y_W-1:0]     end_y;
  logic [lr_pkg::COLOR_W-1:0] color;

  modport source (output valid, action, start_x, start_y, end_x, end_y, color,
                  input ready);
  modport sink   (input valid, action, start_x, start_y, end_x, end_y, color,
                  output ready);
endinterface

interface lr_out_if;
  logic                       valid;
  logic                       ready;
  logic [lr_pkg::X_W-1:0]     pixel_x;
  logic [lr_pkg::Y_W-1:0]     pixel_y;
  logic [lr_pkg::ADDR_W-1:0]  address;
  logic [lr_pkg::COLOR_W-1:0] pixel_color;
  logic                       last;

  modport source (output valid, pixel_x, pixel_y, address, pixel_color, last,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, address, pixel_color, last,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/line_rasterizer.sv
// Top level of the Bresenham line rasterizer.
//
//  channel   dir  handshake          word
//  in_chan   in   valid/ready        action, start_x, start_y, end_x, end_y, color
//  out_chan  out  valid/ready        pixel_x, pixel_y, address, pixel_color, last
//  cfg_*     in   cfg_we             cfg_wdata -> frame_base
//
// One word per cycle while the output is not stalled: a word is held in the input
// register, passes through the engine and its pixel is registered in the output register.
// The set-up of a start word and the step share one pass of the engine.
// Reset (rst_n low, synchronous) empties both registers, ends any line and
// loads the frame base. A stalled output holds its pixel; the input register
// still takes one more word behind it.
`default_nettype none

module line_rasterizer #(
  parameter int X_LIMIT = lr_pkg::X_LIMIT_DEF,
  parameter int Y_LIMIT = lr_pkg::Y_LIMIT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  lr_in_if.sink                           in_chan,
  lr_out_if.source                        out_chan,
  input  wire logic                       cfg_we,
  input  wire logic [lr_pkg::ADDR_W-1:0]  cfg_wdata
);
  import lr_pkg::*;

  logic       item_valid;
  lr_item_t   item;
  lr_result_t res;
  logic       free;
  logic       fire;

  // A word moves through the engine when the output register has room
  assign fire = item_valid && free;

  lr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  lr_engine #(
    .X_LIMIT (X_LIMIT),
    .Y_LIMIT (Y_LIMIT)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (item),
    .res       (res)
  );

  lr_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .free     (free),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

>>> rtl/lr_in_stage.sv
// Input register stage: captures one command word ahead of the engine.
`default_nettype none

module lr_in_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  lr_in_if.sink                 in_chan,
  input  wire logic             take,
  output logic                  item_valid,
  output lr_pkg::lr_item_t      item
);
  import lr_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  lr_item_t item_r;
  logic     load;

  // Free when empty or when the held word moves on this cycle
  assign in_chan.ready = !valid_r || take;
  assign load          = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= '{action:  in_chan.action,
                  start_x: in_chan.start_x,
                  start_y: in_chan.start_y,
                  end_x:   in_chan.end_x,
                  end_y:   in_chan.end_y,
                  color:   in_chan.color};
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

>>> rtl/lr_engine.sv
// Bresenham engine: line set-up, pixel emit and one-step advance per word.
`default_nettype none

module lr_engine #(
  parameter int X_LIMIT = lr_pkg::X_LIMIT_DEF,
  parameter int Y_LIMIT = lr_pkg::Y_LIMIT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [lr_pkg::ADDR_W-1:0]  cfg_wdata,
  input  wire logic                       fire,
  input  wire lr_pkg::lr_item_t           item,
  output lr_pkg::lr_result_t              res
);
  import lr_pkg::*;

  localparam logic [POS_W-1:0] XL = POS_W'(X_LIMIT);
  localparam logic [POS_W-1:0] YL = POS_W'(Y_LIMIT);

  // Line state
  logic [ADDR_W-1:0]  frame_base_r;
  logic               active_r;
  logic               steep_r;
  logic [POS_W-1:0]   major_pos_r;
  logic [POS_W-1:0]   major_end_r;
  logic [POS_W-1:0]   minor_pos_r;
  logic [ERR_W-1:0]   err_r;
  logic [POS_W-1:0]   major_delta_r;
  logic [POS_W-1:0]   minor_delta_r;
  logic               dir_down_r;
  logic [COLOR_W-1:0] color_r;

  // Set-up terms
  logic             start;
  logic [POS_W-1:0] x0, y0, x1, y1, dx, dy;
  logic [POS_W-1:0] a0, b0, a1, b1, sa0, sb0, sa1, sb1;
  logic             s_steep;
  logic [POS_W-1:0] s_maj_d, s_min_d;
  logic [ERR_W-1:0] s_err;

  // Current position and advance
  logic               c_steep, c_dir;
  logic [POS_W-1:0]   c_maj, c_end, c_min, c_maj_d, c_min_d;
  logic [ERR_W-1:0]   c_err;
  logic [COLOR_W-1:0] c_color;
  logic [POS_W-1:0]   px, py;
  logic               is_last, emit, err_ge;
  logic [ERR_W:0]     err_sum;
  logic [ERR_W-1:0]   err_sub;
  logic [ERR_W-1:0]   err_nxt;
  logic [POS_W-1:0]   maj_nxt, min_nxt;
  logic               active_nxt;

  // Saturate endpoints to the screen limits
  always_comb begin
    x0 = (item.start_x > XL) ? XL : item.start_x;
    x1 = (item.end_x > XL) ? XL : item.end_x;
    y0 = ({1'b0, item.start_y} > YL) ? YL : {1'b0, item.start_y};
    y1 = ({1'b0, item.end_y} > YL) ? YL : {1'b0, item.end_y};
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = (y1 > y0) ? y1 - y0 : y0 - y1;
  end

  // Axis swap for steep lines, then order along the major axis
  always_comb begin
    s_steep = dy > dx;
    a0 = s_steep ? y0 : x0;
    b0 = s_steep ? x0 : y0;
    a1 = s_steep ? y1 : x1;
    b1 = s_steep ? x1 : y1;
    if (a0 > a1) begin
      sa0 = a1; sb0 = b1; sa1 = a0; sb1 = b0;
    end else begin
      sa0 = a0; sb0 = b0; sa1 = a1; sb1 = b1;
    end
    s_maj_d = sa1 - sa0;
    s_min_d = (sb1 > sb0) ? sb1 - sb0 : sb0 - sb1;
    s_err   = ERR_W'(0) - {2'b00, s_maj_d[POS_W-1:1]};
  end

  // Pick fresh set-up on a start word, held state otherwise
  assign start = (item.action == ACT_START);
  assign emit  = start || active_r;

  always_comb begin
    if (start) begin
      c_steep = s_steep;  c_maj = sa0;        c_end = sa1;
      c_min   = sb0;      c_maj_d = s_maj_d;  c_min_d = s_min_d;
      c_dir   = sb0 < sb1; c_err = s_err;     c_color = item.color;
    end else begin
      c_steep = steep_r;    c_maj = major_pos_r;     c_end = major_end_r;
      c_min   = minor_pos_r; c_maj_d = major_delta_r; c_min_d = minor_delta_r;
      c_dir   = dir_down_r;  c_err = err_r;           c_color = color_r;
    end
  end

  // Emitted pixel
  assign px      = c_steep ? c_min : c_maj;
  assign py      = c_steep ? c_maj : c_min;
  assign is_last = (c_maj == c_end);

  // One Bresenham step
  always_comb begin
    err_sum = {c_err[ERR_W-1], c_err} + {2'b00, c_min_d};
    err_ge  = !err_sum[ERR_W];
    err_sub = err_sum[ERR_W-1:0] - {1'b0, c_maj_d};
    err_nxt = err_ge ? err_sub : err_sum[ERR_W-1:0];
    if (err_ge) begin
      min_nxt = c_dir ? c_min + POS_W'(1) : c_min - POS_W'(1);
    end else begin
      min_nxt = c_min;
    end
    maj_nxt    = c_maj + POS_W'(1);
    active_nxt = active_r;
    if (fire && emit) begin
      active_nxt = !is_last;
    end
  end

  always_comb begin
    res.valid             = fire && emit;
    res.pixel.pixel_x     = px;
    res.pixel.pixel_y     = py[Y_W-1:0];
    res.pixel.address     = frame_base_r + {13'd0, py, 10'd0} + {22'd0, px, 1'b0};
    res.pixel.pixel_color = c_color;
    res.pixel.last        = is_last;
  end

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      frame_base_r <= FRAME_BASE_RST;
    end else begin
      active_r <= active_nxt;
      if (cfg_we) begin
        frame_base_r <= cfg_wdata;
      end
    end
  end

  // Line datapath registers
  always_ff @(posedge clk) begin
    if (fire && emit) begin
      steep_r       <= c_steep;
      major_end_r   <= c_end;
      major_delta_r <= c_maj_d;
      minor_delta_r <= c_min_d;
      dir_down_r    <= c_dir;
      color_r       <= c_color;
      major_pos_r   <= maj_nxt;
      minor_pos_r   <= min_nxt;
      err_r         <= err_nxt;
    end
  end

  // A finished line leaves the engine idle
  a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && emit && is_last) |=> !active_r)
    else $error("engine still active after last pixel");

  // While drawing, the major position has not passed the end point
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (major_pos_r <= major_end_r))
    else $error("major position beyond end point");

  // Between steps the error term is never positive and the minor slope at most one
  a_err_neg: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> ((err_r[ERR_W-1] || (err_r == '0)) && (minor_delta_r <= major_delta_r)))
    else $error("error term or deltas out of range");

endmodule

`default_nettype wire

>>> rtl/lr_out_stage.sv
// Output register stage: holds one pixel word until the sink takes it.
`default_nettype none

module lr_out_stage (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lr_pkg::lr_result_t  res,
  output logic                     free,
  lr_out_if.source                 out_chan
);
  import lr_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  lr_pixel_t pixel_r;

  // Room for a new word when empty or being drained now
  assign free = !valid_r || out_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (free) begin
      valid_nxt = res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (free && res.valid) begin
      pixel_r <= res.pixel;
    end
  end

  assign out_chan.valid       = valid_r;
  assign out_chan.pixel_x     = pixel_r.pixel_x;
  assign out_chan.pixel_y     = pixel_r.pixel_y;
  assign out_chan.address     = pixel_r.address;
  assign out_chan.pixel_color = pixel_r.pixel_color;
  assign out_chan.last        = pixel_r.last;

endmodule

`default_nettype wire

>>> bench/tb_line_rasterizer.sv
// Self-checking testbench for the line rasterizer: directed, random and stall tests.
`timescale 1ns / 100ps

module tb_line_rasterizer;
  import lr_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 6;     // settling margin after the last pixel is taken
  localparam int ITEM_W      = $bits(lr_item_t);

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [ADDR_W-1:0] cfg_wdata;

  lr_in_if  in_chan ();
  lr_out_if out_chan ();

  line_rasterizer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Line state of the predictor
  bit                 lr_busy;
  bit                 lr_steep;
  logic [POS_W-1:0]   mjr_pos;
  logic [POS_W-1:0]   mjr_end;
  logic [POS_W-1:0]   mnr_pos;
  int                 err_acc;
  int                 mjr_span;
  int                 mnr_span;
  bit                 mnr_down;
  logic [COLOR_W-1:0] ink;
  logic [ADDR_W-1:0]  base_now;

  lr_pixel_t pending_pixels[$];
  int        errors;
  int        cycle_count;
  bit        src_idle;
  bit        sink_idle;
  bit        sink_hold;
  int unsigned sink_wait;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** line_rasterizer: FAILED **");
      $finish;
    end
  end

  function automatic int clip(input int v, input int lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic int absdiff(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Predicts the pixel that one accepted word yields; returns 0 if none
  function automatic bit rasterize_word(input lr_item_t w, output lr_pixel_t px);
    int x0, y0, x1, y1, a0, b0, a1, b1, t;
    logic [POS_W-1:0] cx, cy;
    px = '0;
    if (w.action == ACT_START) begin
      x0 = clip(int'(w.start_x), X_LIMIT_DEF);
      y0 = clip(int'(w.start_y), Y_LIMIT_DEF);
      x1 = clip(int'(w.end_x), X_LIMIT_DEF);
      y1 = clip(int'(w.end_y), Y_LIMIT_DEF);
      lr_steep = absdiff(y1, y0) > absdiff(x1, x0);
      if (lr_steep) begin
        a0 = y0; b0 = x0; a1 = y1; b1 = x1;
      end else begin
        a0 = x0; b0 = y0; a1 = x1; b1 = y1;
      end
      // major axis always runs upwards
      if (a0 > a1) begin
        t = a0; a0 = a1; a1 = t;
        t = b0; b0 = b1; b1 = t;
      end
      mjr_pos  = POS_W'(a0);
      mjr_end  = POS_W'(a1);
      mnr_pos  = POS_W'(b0);
      mjr_span = a1 - a0;
      mnr_span = absdiff(b1, b0);
      mnr_down = b0 < b1;
      err_acc  = -(mjr_span / 2);
      ink      = w.color;
      lr_busy  = 1'b1;
    end else if (!lr_busy) begin
      return 1'b0;
    end
    cx = lr_steep ? mnr_pos : mjr_pos;
    cy = lr_steep ? mjr_pos : mnr_pos;
    px.pixel_x     = cx;
    px.pixel_y     = cy[Y_W-1:0];
    px.address     = base_now + ({23'd0, cy} << 10) + ({23'd0, cx} << 1);
    px.pixel_color = ink;
    px.last        = (mjr_pos == mjr_end);
    if (px.last) begin
      lr_busy = 1'b0;
    end else begin
      err_acc += mnr_span;
      if (err_acc >= 0) begin
        mnr_pos = mnr_down ? mnr_pos + 1'b1 : mnr_pos - 1'b1;
        err_acc -= mjr_span;
      end
      mjr_pos = mjr_pos + 1'b1;
    end
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    errors++;
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // Result checker
  always @(posedge clk) begin
    lr_pixel_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_pixels.size() == 0) begin
        flag_mismatch("unexpected pixel_x", 32'(out_chan.pixel_x), 32'd0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_chan.pixel_x !== want.pixel_x)
          flag_mismatch("pixel_x", 32'(out_chan.pixel_x), 32'(want.pixel_x));
        if (out_chan.pixel_y !== want.pixel_y)
          flag_mismatch("pixel_y", 32'(out_chan.pixel_y), 32'(want.pixel_y));
        if (out_chan.address !== want.address)
          flag_mismatch("address", out_chan.address, want.address);
        if (out_chan.pixel_color !== want.pixel_color)
          flag_mismatch("pixel_color", 32'(out_chan.pixel_color), 32'(want.pixel_color));
        if (out_chan.last !== want.last)
          flag_mismatch("last", 32'(out_chan.last), 32'(want.last));
      end
    end
  end

  // Pixel receiver: random stall after each word while sink_idle is set, plus the long hold-off
  initial begin
    int unsigned nxt;
    out_chan.ready <= 1'b0;
    sink_wait      <= 0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_chan.ready <= 1'b0;
        sink_wait      <= 0;
      end else begin
        if (out_chan.valid && out_chan.ready)
          nxt = sink_idle ? $urandom_range(0, 19) : 0;
        else
          nxt = (sink_wait != 0) ? sink_wait - 1 : 0;
        sink_wait      <= nxt;
        out_chan.ready <= (nxt == 0) && !sink_hold;
      end
    end
  end

  // Sends one command word and records the pixel it should give
  task automatic send_word(input lr_item_t w, output bit made);
    int gap;
    lr_pixel_t px;
    gap = src_idle ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.action  <= w.action;
    in_chan.start_x <= w.start_x;
    in_chan.start_y <= w.start_y;
    in_chan.end_x   <= w.end_x;
    in_chan.end_y   <= w.end_y;
    in_chan.color   <= w.color;
    do @(posedge clk); while (!in_chan.ready);
    made = rasterize_word(w, px);
    if (made) pending_pixels.push_back(px);
  endtask

  // Stops offering words and waits for every pixel, then lets the engine settle
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_frame_base(input logic [ADDR_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    base_now  = value;
  endtask

  function automatic lr_item_t start_word(input int x0, input int y0, input int x1,
                                          input int y1, input int c);
    lr_item_t w;
    w.action  = ACT_START;
    w.start_x = X_W'(x0);
    w.start_y = Y_W'(y0);
    w.end_x   = X_W'(x1);
    w.end_y   = Y_W'(y1);
    w.color   = COLOR_W'(c);
    return w;
  endfunction

  // Step word with junk in the unused fields
  function automatic lr_item_t step_word();
    lr_item_t w;
    w = lr_item_t'(ITEM_W'({$urandom, $urandom}));
    w.action = ACT_STEP;
    return w;
  endfunction

  task automatic send_steps(input int n);
    bit made;
    repeat (n) send_word(step_word(), made);
  endtask

  function automatic int rand_col();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(320, 511) : $urandom_range(0, 319);
  endfunction

  function automatic int rand_row();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(240, 255) : $urandom_range(0, 239);
  endfunction

  function automatic int near(input int v, input int top);
    int r;
    r = v + $urandom_range(0, 24) - 12;
    return (r < 0) ? 0 : (r > top) ? top : r;
  endfunction

  // One random line: mostly short, walked to its end, sometimes cut short
  task automatic send_line(output int made);
    int kind, x0, y0, x1, y1, left, steps;
    bit got;
    kind = $urandom_range(0, 9);
    x0 = rand_col();
    y0 = rand_row();
    if (kind == 0) begin
      x1 = x0; y1 = y0;
    end else if (kind <= 2) begin
      x1 = rand_col(); y1 = rand_row();
    end else begin
      x1 = near(x0, 511); y1 = near(y0, 255);
    end
    send_word(start_word(x0, y0, x1, y1, $urandom_range(0, 65535)), got);
    made = 1;
    left = lr_busy ? int'(mjr_end) - int'(mjr_pos) + 1 : 0;
    if (left > 0 && $urandom_range(0, 4) == 0)
      steps = $urandom_range(0, left - 1);
    else
      steps = left + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
    repeat (steps) begin
      send_word(step_word(), got);
      made += got;
    end
  endtask

  task automatic run_lines(input int n);
    int total, made;
    total = 0;
    while (total < n) begin
      send_line(made);
      total += made;
    end
  endtask

  // Points, edges of the screen, clipping, both axes, abandoned line
  task automatic test_corner_lines();
    bit made;
    send_word(start_word(0, 0, 0, 0, 0), made);
    send_steps(1);                                     // step with no line
    send_word(start_word(319, 239, 319, 239, 16'hFFFF), made);
    send_word(start_word(511, 255, 400, 250, 16'hA5A5), made);  // both ends clipped
    send_word(start_word(10, 5, 13, 5, 16'h1234), made);
    send_steps(4);                                     // last step finds no line
    send_word(start_word(7, 20, 5, 16, 16'h5A5A), made);       // steep, drawn backwards
    send_steps(4);
    send_word(start_word(0, 0, 8, 3, 16'h0F0F), made);
    send_steps(2);
    send_word(start_word(300, 200, 297, 203, 16'hF0F0), made); // restart mid line
    send_steps(4);
  endtask

  task automatic test_frame_base_sweep();
    logic [ADDR_W-1:0] bases[5];
    bases = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFC_0000, $urandom, $urandom};
    foreach (bases[i]) begin
      set_frame_base(bases[i]);
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle <= ($urandom_range(0, 3) != 0);
      run_lines(260);
    end
  endtask

  task automatic test_full_rate();
    src_idle  = 1'b0;
    sink_idle <= 1'b0;
    run_lines(150);
  endtask

  // Receiver holds off long enough for the block to back up into its input
  task automatic test_backpressure();
    wait_drained();
    src_idle  = 1'b0;
    sink_idle <= 1'b1;
    fork
      begin
        sink_hold <= 1'b1;
        repeat (300) @(posedge clk);
        sink_hold <= 1'b0;
      end
    join_none
    run_lines(60);
    wait_drained();
    src_idle = 1'b1;
    run_lines(40);
  endtask

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    in_chan.valid   <= 1'b0;
    in_chan.action  <= ACT_START;
    in_chan.start_x <= '0;
    in_chan.start_y <= '0;
    in_chan.end_x   <= '0;
    in_chan.end_y   <= '0;
    in_chan.color   <= '0;
    sink_hold       <= 1'b0;
    sink_idle       <= 1'b1;
    src_idle         = 1'b1;
    errors           = 0;
    lr_busy          = 1'b0;
    lr_steep         = 1'b0;
    mjr_pos          = '0;
    mjr_end          = '0;
    mnr_pos          = '0;
    err_acc          = 0;
    mjr_span         = 0;
    mnr_span         = 0;
    mnr_down         = 1'b0;
    ink              = '0;
    base_now         = FRAME_BASE_RST;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_lines();
    test_frame_base_sweep();
    test_full_rate();
    test_backpressure();
    wait_drained();

    if (errors == 0) begin
      $display("** line_rasterizer: PASSED **");
    end else begin
      $display("** line_rasterizer: FAILED **");
    end
    $finish;
  end

endmodule
